// File: design/swmh_pkg.sv
// Shared constants and defaults for the sliding window minimum block.
`timescale 1ns / 1ps
`default_nettype none

package swmh_pkg;

   // Default ring depth and stored sample width.
   localparam int DEPTH_DEFAULT       = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 64;

   // Fixed field widths of the channels and the window register.
   localparam int SAMPLE_FIELD_BITS = 64;
   localparam int INDEX_BITS        = 32;
   localparam int WINDOW_BITS       = 11;
   localparam int COUNT_OUT_BITS    = 11;

   // Window length after reset, before clamping to the ring depth.
   localparam int WINDOW_RESET = 64;

endpackage

`default_nettype wire

// File: design/swmh_channels.sv
// Valid/ready channel interfaces for the sample requests and the minimum responses.
`timescale 1ns / 1ps
`default_nettype none

interface swmh_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [swmh_pkg::SAMPLE_FIELD_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swmh_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [swmh_pkg::SAMPLE_FIELD_BITS-1:0] min_value;
   logic [swmh_pkg::INDEX_BITS-1:0]        min_index;
   logic [swmh_pkg::INDEX_BITS-1:0]        newest_index;
   logic [swmh_pkg::INDEX_BITS-1:0]        oldest_index;
   logic [swmh_pkg::COUNT_OUT_BITS-1:0]    held_count;
   logic                                   window_full;

   modport source (output valid, output min_value, output min_index, output newest_index,
                   output oldest_index, output held_count, output window_full, input ready);
   modport sink   (input valid, input min_value, input min_index, input newest_index,
                   input oldest_index, input held_count, input window_full, output ready);
endinterface

`default_nettype wire

// File: design/sliding_window_min_history.sv
// Sliding window minimum over a ring of past samples, with rescan on minimum departure.
// A request transfer goes to the publish state, which registers the response, when no
// rescan is needed; if the departing sample held the minimum, a scan state first reads
// the window, one ring entry per cycle through the single read port of sample memory.
// Throughput: one sample at a time; the next request is taken once the response is
// registered. Synchronous active-high reset clears indices, counts and the minimum and
// sets the window to 64 (clamped to DEPTH); the ring memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_history #(
   parameter int DEPTH       = swmh_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = swmh_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   swmh_req_if.sink                              req_chan,
   swmh_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [swmh_pkg::WINDOW_BITS-1:0] csr_wr_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = swmh_pkg::INDEX_BITS;
   localparam int WB = swmh_pkg::WINDOW_BITS;

   localparam logic [31:0]   DEPTH32      = 32'(DEPTH);
   localparam logic [PW-1:0] LAST_SLOT    = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT   = CW'(DEPTH);
   localparam int            WINDOW_INIT  = (swmh_pkg::WINDOW_RESET > DEPTH) ?
                                            DEPTH : swmh_pkg::WINDOW_RESET;
   localparam logic [WB-1:0] WINDOW_RESET = WB'(WINDOW_INIT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PUBLISH
   } state_type;

   // Sample ring memory with a registered read port.
   logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   state_type              state_ff, state_in;
   logic [PW-1:0]          ring_pos_ff, ring_pos_in;
   logic [IW-1:0]          next_index_ff, next_index_in;
   logic [CW-1:0]          stored_count_ff, stored_count_in;
   logic [IW-1:0]          best_index_ff, best_index_in;
   logic [SAMPLE_BITS-1:0] best_value_ff, best_value_in;
   logic [WB-1:0]          window_ff, window_in;
   logic [IW-1:0]          cur_index_ff, cur_index_in;

   logic [PW-1:0]          rd_addr_ff, rd_addr_in;
   logic [CW-1:0]          issue_left_ff, issue_left_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   scan_first_ff, scan_first_in;
   logic [IW-1:0]          scan_index_ff, scan_index_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] out_value_ff, out_value_in;
   logic [IW-1:0]          out_min_index_ff, out_min_index_in;
   logic [IW-1:0]          out_newest_ff, out_newest_in;
   logic [IW-1:0]          out_oldest_ff, out_oldest_in;
   logic [swmh_pkg::COUNT_OUT_BITS-1:0] out_count_ff, out_count_in;
   logic                   out_full_ff, out_full_in;

   logic                   req_xfer;
   logic                   rd_en;
   logic                   out_load;
   logic [SAMPLE_BITS-1:0] new_sample;
   logic [31:0]            w32;
   logic [31:0]            before32;
   logic [31:0]            count32;
   logic [31:0]            slot32;
   logic [31:0]            back32;
   logic [31:0]            start32;
   logic [31:0]            cfg32;
   logic [CW-1:0]          after_count;
   logic                   departs;

   // Requests are taken only between items; a rescan holds off the next sample.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign new_sample     = req_chan.sample[SAMPLE_BITS-1:0];
   assign rd_en          = (state_ff == ST_SCAN) && (issue_left_ff != '0);
   assign out_load       = (state_ff == ST_PUBLISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Widened copies for comparisons and slot arithmetic.
   assign w32      = 32'(window_ff);
   assign before32 = 32'(stored_count_ff);
   assign count32  = 32'(stored_count_ff);
   assign slot32   = 32'(ring_pos_ff);
   assign back32   = w32 - 32'd1;
   assign start32  = (slot32 >= back32) ? (slot32 - back32) : (slot32 + DEPTH32 - back32);
   assign cfg32    = 32'(csr_wr_data);

   assign after_count = (stored_count_ff == FULL_COUNT) ? FULL_COUNT
                                                         : stored_count_ff + 1'b1;
   assign departs     = (before32 >= w32) && (best_index_ff == next_index_ff - w32);

   // Next-state logic for tracking, rescan and the response register.
   always_comb begin
      state_in         = state_ff;
      ring_pos_in      = ring_pos_ff;
      next_index_in    = next_index_ff;
      stored_count_in  = stored_count_ff;
      best_index_in    = best_index_ff;
      best_value_in    = best_value_ff;
      window_in        = window_ff;
      cur_index_in     = cur_index_ff;
      rd_addr_in       = rd_addr_ff;
      issue_left_in    = issue_left_ff;
      rd_valid_in      = rd_en;
      scan_first_in    = scan_first_ff;
      scan_index_in    = scan_index_ff;
      out_value_in     = out_value_ff;
      out_min_index_in = out_min_index_ff;
      out_newest_in    = out_newest_ff;
      out_oldest_in    = out_oldest_ff;
      out_count_in     = out_count_ff;
      out_full_in      = out_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ring_pos_in     = (ring_pos_ff == LAST_SLOT) ? '0 : ring_pos_ff + 1'b1;
               next_index_in   = next_index_ff + 1'b1;
               stored_count_in = after_count;
               cur_index_in    = next_index_ff;
               state_in        = ST_PUBLISH;
               if (stored_count_ff == '0 || window_ff == WB'(1)) begin
                  best_value_in = new_sample;
                  best_index_in = next_index_ff;
               end else if (new_sample < best_value_ff) begin
                  best_value_in = new_sample;
                  best_index_in = next_index_ff;
               end else if (departs) begin
                  // Minimum leaves the window: rescan it oldest first.
                  rd_addr_in    = start32[PW-1:0];
                  issue_left_in = w32[CW-1:0];
                  scan_first_in = 1'b1;
                  scan_index_in = next_index_ff - back32;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_left_ff != '0) begin
               rd_addr_in    = (rd_addr_ff == LAST_SLOT) ? '0 : rd_addr_ff + 1'b1;
               issue_left_in = issue_left_ff - 1'b1;
            end
            if (rd_valid_ff) begin
               // Strict compare keeps the first occurrence of the minimum.
               if (scan_first_ff || rd_data_ff < best_value_ff) begin
                  best_value_in = rd_data_ff;
                  best_index_in = scan_index_ff;
               end
               scan_first_in = 1'b0;
               scan_index_in = scan_index_ff + 1'b1;
               if (issue_left_ff == '0) begin
                  state_in = ST_PUBLISH;
               end
            end
         end
         ST_PUBLISH: begin
            if (out_load) begin
               out_value_in     = best_value_ff;
               out_min_index_in = best_index_ff;
               out_newest_in    = cur_index_ff;
               out_oldest_in    = cur_index_ff - count32 + 32'd1;
               out_count_in     = count32[swmh_pkg::COUNT_OUT_BITS-1:0];
               out_full_in      = (count32 >= w32);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A window write clamps the length and restarts tracking.
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            window_in = WB'(1);
         end else if (cfg32 > DEPTH32) begin
            window_in = DEPTH32[WB-1:0];
         end else begin
            window_in = csr_wr_data;
         end
         stored_count_in = '0;
         best_index_in   = '0;
         best_value_in   = '1;
      end
   end

   // Response valid holds until the transfer completes.
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ring_pos_ff     <= '0;
         next_index_ff   <= '0;
         stored_count_ff <= '0;
         best_index_ff   <= '0;
         best_value_ff   <= '1;
         window_ff       <= WINDOW_RESET;
         issue_left_ff   <= '0;
         rd_valid_ff     <= 1'b0;
         scan_first_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ring_pos_ff     <= ring_pos_in;
         next_index_ff   <= next_index_in;
         stored_count_ff <= stored_count_in;
         best_index_ff   <= best_index_in;
         best_value_ff   <= best_value_in;
         window_ff       <= window_in;
         issue_left_ff   <= issue_left_in;
         rd_valid_ff     <= rd_valid_in;
         scan_first_ff   <= scan_first_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cur_index_ff     <= cur_index_in;
      rd_addr_ff       <= rd_addr_in;
      scan_index_ff    <= scan_index_in;
      out_value_ff     <= out_value_in;
      out_min_index_ff <= out_min_index_in;
      out_newest_ff    <= out_newest_in;
      out_oldest_ff    <= out_oldest_in;
      out_count_ff     <= out_count_in;
      out_full_ff      <= out_full_in;
   end

   // Ring memory: the sample is written on transfer, rescan reads follow later.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ring_mem[ring_pos_ff] <= new_sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr_ff];
      end
   end

   // Response channel drive.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.min_value    = swmh_pkg::SAMPLE_FIELD_BITS'(out_value_ff);
   assign rsp_chan.min_index    = out_min_index_ff;
   assign rsp_chan.newest_index = out_newest_ff;
   assign rsp_chan.oldest_index = out_oldest_ff;
   assign rsp_chan.held_count   = out_count_ff;
   assign rsp_chan.window_full  = out_full_ff;

endmodule

`default_nettype wire

// File: design/swmh_checker.sv
// Port-level checks for the sliding window minimum block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module swmh_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic [swmh_pkg::SAMPLE_FIELD_BITS-1:0] rsp_min_value,
   input wire logic [swmh_pkg::INDEX_BITS-1:0]        rsp_min_index,
   input wire logic [swmh_pkg::INDEX_BITS-1:0]        rsp_newest_index,
   input wire logic [swmh_pkg::INDEX_BITS-1:0]        rsp_oldest_index
);

   // A pending response stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before transfer");

   // A stalled response keeps its minimum value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_min_value))
      else $error("stalled response value changed");

   // One sample in flight: a request transfer closes the request side next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a sample was still in work");

   // With a single held sample, that sample is the minimum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_oldest_index == rsp_newest_index) |-> rsp_min_index == rsp_newest_index)
      else $error("single held sample is not reported as the minimum");

endmodule

bind sliding_window_min_history swmh_checker u_swmh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_min_value    (rsp_chan.min_value),
   .rsp_min_index    (rsp_chan.min_index),
   .rsp_newest_index (rsp_chan.newest_index),
   .rsp_oldest_index (rsp_chan.oldest_index)
);

`default_nettype wire
